>>> rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg: shared types and constants of the i2c transaction sequencer
// Command codes, default poll limit and the input and result item layouts.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int          TIMEOUT_BITS  = 18;
  localparam int unsigned TIMEOUT_RESET = 160000;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // command codes; the unused code behaves as a poll
  localparam logic [1:0] CMD_START_WRITE = 2'd0;
  localparam logic [1:0] CMD_START_READ  = 2'd1;
  localparam logic [1:0] CMD_POLL        = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] target_address;
    logic [7:0] length;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       bus_busy;
    logic       start_sent;
    logic       address_acked;
    logic       ack_failure;
    logic       tx_empty;
    logic       transfer_finished;
    logic       rx_not_empty;
  } item_t;

  typedef struct packed {
    logic       issue_start;
    logic       write_data;
    logic [7:0] data_out;
    logic       issue_stop;
    logic       clear_fault;
    logic       ack_enable;
    logic       read_valid;
    logic [7:0] read_data;
    logic [7:0] byte_index;
    logic       done_res;
    logic       failed;
  } result_t;

endpackage

>>> rtl/i2cseq_in_stage.sv
// ----------------------------------------------------------------------------
// i2cseq_in_stage: input register
// Holds one accepted item until the sequencer steps on it.
// ----------------------------------------------------------------------------
module i2cseq_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cseq_pkg::item_t   in_item,
  input  logic                advance,
  output logic                held_valid,
  output i2cseq_pkg::item_t   held_item
);

  // free when empty or when the held item moves on this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

>>> rtl/i2cseq_fsm.sv
// ----------------------------------------------------------------------------
// i2cseq_fsm: transaction phase sequencer
// Steps the transaction phase once per item and forms its result.
// ----------------------------------------------------------------------------
module i2cseq_fsm #(
  parameter int TIMEOUT_BITS = i2cseq_pkg::TIMEOUT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [TIMEOUT_BITS-1:0]   cfg_data,
  input  logic                      step,
  input  i2cseq_pkg::item_t         item,
  output i2cseq_pkg::result_t       res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BUSY,
    PH_START,
    PH_ADDR,
    PH_DATA,
    PH_BTF
  } phase_t;

  phase_t                  phase, phase_next;
  logic                    is_read, is_read_next;
  logic [6:0]              slave_address, slave_address_next;
  logic [7:0]              byte_count, byte_count_next;
  logic [7:0]              current_index, current_index_next;
  logic [TIMEOUT_BITS-1:0] wait_counter, wait_counter_next;
  logic                    ack_level, ack_level_next;
  logic [TIMEOUT_BITS-1:0] timeout_limit;

  logic [TIMEOUT_BITS-1:0] cnt_inc;
  logic                    timed_out;
  logic [7:0]              idx_inc;
  logic [8:0]              idx_inc2;
  logic                    is_start;

  // saturating poll count of the current bounded wait
  assign cnt_inc   = (wait_counter != '1) ? wait_counter + 1'b1 : wait_counter;
  assign timed_out = (cnt_inc >= timeout_limit);
  assign idx_inc   = current_index + 8'd1;
  assign idx_inc2  = {1'b0, idx_inc} + 9'd1;
  assign is_start  = item.command inside {i2cseq_pkg::CMD_START_WRITE,
                                          i2cseq_pkg::CMD_START_READ};

  always_comb begin
    phase_next         = phase;
    is_read_next       = is_read;
    slave_address_next = slave_address;
    byte_count_next    = byte_count;
    current_index_next = current_index;
    wait_counter_next  = wait_counter;
    ack_level_next     = ack_level;
    res                = '0;

    if (is_start) begin
      // a start outside idle is dropped
      if (phase == PH_IDLE) begin
        is_read_next       = (item.command == i2cseq_pkg::CMD_START_READ);
        slave_address_next = item.target_address;
        byte_count_next    = item.length;
        current_index_next = '0;
        wait_counter_next  = '0;
        phase_next         = PH_BUSY;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_BUSY: begin
          if (!item.bus_busy) begin
            res.issue_start   = 1'b1;
            phase_next        = PH_START;
            wait_counter_next = '0;
          end else begin
            wait_counter_next = cnt_inc;
            if (timed_out) begin
              res.done_res = 1'b1;
              res.failed   = 1'b1;
              phase_next   = PH_IDLE;
            end
          end
        end
        PH_START: begin
          if (item.start_sent) begin
            res.write_data    = 1'b1;
            res.data_out      = {slave_address, is_read};
            phase_next        = PH_ADDR;
            wait_counter_next = '0;
          end else begin
            wait_counter_next = cnt_inc;
            if (timed_out) begin
              res.done_res = 1'b1;
              res.failed   = 1'b1;
              phase_next   = PH_IDLE;
            end
          end
        end
        PH_ADDR: begin
          if (item.ack_failure) begin
            res.clear_fault = 1'b1;
            res.issue_stop  = 1'b1;
            res.done_res    = 1'b1;
            res.failed      = 1'b1;
            phase_next      = PH_IDLE;
          end else if (item.address_acked) begin
            wait_counter_next = '0;
            if (is_read) begin
              ack_level_next = (byte_count != 8'd1);
            end
            if (byte_count == 8'd0) begin
              res.issue_stop = 1'b1;
              res.done_res   = 1'b1;
              phase_next     = PH_IDLE;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            wait_counter_next = cnt_inc;
            if (timed_out) begin
              res.issue_stop = 1'b1;
              res.done_res   = 1'b1;
              res.failed     = 1'b1;
              phase_next     = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          if (is_read) begin
            if (item.rx_not_empty) begin
              res.read_valid     = 1'b1;
              res.read_data      = item.rx_byte;
              res.byte_index     = current_index;
              current_index_next = idx_inc;
              wait_counter_next  = '0;
              if (idx_inc >= byte_count) begin
                res.issue_stop = 1'b1;
                res.done_res   = 1'b1;
                phase_next     = PH_IDLE;
              end else if (idx_inc2 == {1'b0, byte_count}) begin
                // last byte ahead: answer it with a nack
                ack_level_next = 1'b0;
              end
            end else begin
              wait_counter_next = cnt_inc;
              if (timed_out) begin
                res.issue_stop = 1'b1;
                res.done_res   = 1'b1;
                res.failed     = 1'b1;
                phase_next     = PH_IDLE;
              end
            end
          end else begin
            if (item.ack_failure) begin
              res.clear_fault = 1'b1;
              res.issue_stop  = 1'b1;
              res.done_res    = 1'b1;
              res.failed      = 1'b1;
              phase_next      = PH_IDLE;
            end else if (item.tx_empty) begin
              res.write_data     = 1'b1;
              res.data_out       = item.tx_byte;
              res.byte_index     = current_index;
              current_index_next = idx_inc;
              if (idx_inc >= byte_count) begin
                phase_next = PH_BTF;
              end
            end
          end
        end
        PH_BTF: begin
          if (item.ack_failure) begin
            res.clear_fault = 1'b1;
            res.issue_stop  = 1'b1;
            res.done_res    = 1'b1;
            res.failed      = 1'b1;
            phase_next      = PH_IDLE;
          end else if (item.transfer_finished) begin
            res.issue_stop = 1'b1;
            res.done_res   = 1'b1;
            phase_next     = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.ack_enable = ack_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      is_read       <= 1'b0;
      slave_address <= '0;
      byte_count    <= '0;
      current_index <= '0;
      wait_counter  <= '0;
      ack_level     <= 1'b0;
      timeout_limit <= TIMEOUT_BITS'(i2cseq_pkg::TIMEOUT_RESET);
    end else begin
      if (cfg_valid) begin
        timeout_limit <= cfg_data;
      end
      if (step) begin
        phase         <= phase_next;
        is_read       <= is_read_next;
        slave_address <= slave_address_next;
        byte_count    <= byte_count_next;
        current_index <= current_index_next;
        wait_counter  <= wait_counter_next;
        ack_level     <= ack_level_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_fail_ends: assert property (@(posedge clk) disable iff (rst)
    step && res.failed |-> res.done_res)
    else $error("failure reported without transaction end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == PH_IDLE)
    else $error("phase not idle after transaction end");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    step && res.issue_start |=> phase == PH_START)
    else $error("start requested but not waiting for start sent");

  a_read_dir: assert property (@(posedge clk) disable iff (rst)
    step && res.read_valid |-> is_read && !res.write_data)
    else $error("received byte outside a read transaction");
`endif

endmodule

>>> rtl/i2cseq_out_stage.sv
// ----------------------------------------------------------------------------
// i2cseq_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cseq_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  i2cseq_pkg::result_t   load_res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cseq_pkg::result_t   out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

>>> rtl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: polled i2c master transaction sequencer
// Input register, phase sequencer and result register in a two-stage pipe.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: a start command (write or read,
//   with target and length) or a status poll carrying the controller flags,
//   the write byte for the current index and the received byte.
//   m_axis returns exactly one result item per input item: command strobes,
//   address or data byte, ack-enable level, received byte, done and failed.
//   cfg_* writes the poll limit of the bounded waits; write it while idle.
// Timing:
//   an item is held in the input register until the sequencer steps on it;
//   its result is registered in the result register and shows on m_axis.
//   One item per cycle is sustained while m_axis does not stall; the phase
//   register is updated once per item by a single pass through the step logic.
// Reset and stall:
//   reset empties both registers, returns the phase to idle and loads the
//   poll limit default. When m_axis stalls the result holds, the input
//   register takes one more item, then s_axis_tready falls.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int TIMEOUT_BITS = i2cseq_pkg::TIMEOUT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: poll limit
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [TIMEOUT_BITS-1:0]             cfg_data,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // target_address[6:0], length[14:7], tx_byte[22:15], rx_byte[30:23],
  // bus_busy[31], start_sent[32], address_acked[33], ack_failure[34],
  // tx_empty[35], transfer_finished[36], rx_not_empty[37], zero[39:38]
  input  logic [i2cseq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command[1:0]
  input  logic [i2cseq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // issue_start[0], write_data[1], data_out[9:2], issue_stop[10],
  // clear_fault[11], ack_enable[12], read_valid[13], read_data[21:14],
  // byte_index[29:22], done_res[30], failed[31]
  output logic [i2cseq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  i2cseq_pkg::item_t   in_item;
  i2cseq_pkg::item_t   held_item;
  i2cseq_pkg::result_t step_res;
  i2cseq_pkg::result_t out_res;
  logic                held_valid;
  logic                out_free;
  logic                advance;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.command           = s_axis_tuser[1:0];
    in_item.target_address    = s_axis_tdata[6:0];
    in_item.length            = s_axis_tdata[14:7];
    in_item.tx_byte           = s_axis_tdata[22:15];
    in_item.rx_byte           = s_axis_tdata[30:23];
    in_item.bus_busy          = s_axis_tdata[31];
    in_item.start_sent        = s_axis_tdata[32];
    in_item.address_acked     = s_axis_tdata[33];
    in_item.ack_failure       = s_axis_tdata[34];
    in_item.tx_empty          = s_axis_tdata[35];
    in_item.transfer_finished = s_axis_tdata[36];
    in_item.rx_not_empty      = s_axis_tdata[37];
  end

  assign advance = held_valid && out_free;

  i2cseq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2cseq_fsm #(
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (held_item),
    .res       (step_res)
  );

  i2cseq_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_res  (step_res),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {out_res.failed, out_res.done_res, out_res.byte_index,
                         out_res.read_data, out_res.read_valid, out_res.ack_enable,
                         out_res.clear_fault, out_res.issue_stop, out_res.data_out,
                         out_res.write_data, out_res.issue_start};

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the i2c master transaction sequencer
// Streams start commands and status polls into the block and predicts each
// result item cycle-free from its own model of the phase sequencer. Every
// result is compared field by field with the oldest prediction. The poll
// limit is rewritten between phases, and sender gaps and receiver stalls
// vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_W = i2cseq_pkg::TIMEOUT_BITS;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, acts as a poll

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(i2cseq_pkg::TIMEOUT_RESET);

  // status flag masks, bit order as on the bus
  localparam logic [6:0] F_BUSY = 7'h01;
  localparam logic [6:0] F_SB   = 7'h02;
  localparam logic [6:0] F_ADDR = 7'h04;
  localparam logic [6:0] F_AF   = 7'h08;
  localparam logic [6:0] F_TXE  = 7'h10;
  localparam logic [6:0] F_BTF  = 7'h20;
  localparam logic [6:0] F_RXNE = 7'h40;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_BUS_FREE,
    SEQ_START_SENT,
    SEQ_ADDR_ACK,
    SEQ_DATA,
    SEQ_BYTE_DONE
  } seq_phase_e;

  typedef enum logic [1:0] {PLAN_ITEM, PLAN_PHASE, PLAN_PAUSE} plan_kind_e;

  typedef struct {
    plan_kind_e          kind;
    i2cseq_pkg::item_t   it;
    logic                write_limit;
    logic [LIMIT_W-1:0]  limit;
    int                  send_pct;
    int                  stall_pct;
  } plan_t;

  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                cfg_valid     = 1'b0;
  logic                                cfg_ready;
  logic [LIMIT_W-1:0]                  cfg_data      = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [i2cseq_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [i2cseq_pkg::IN_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [i2cseq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  plan_t               poll_plan[$];
  i2cseq_pkg::result_t expected_results[$];
  int                  planned_items = 0;
  int                  mismatches    = 0;
  int                  cycle_count   = 0;
  int                  quiet_cycles  = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;

  // sequencer model state
  seq_phase_e          seq_phase  = SEQ_IDLE;
  logic                read_xfer  = 1'b0;
  logic [6:0]          target     = '0;
  logic [7:0]          xfer_len   = '0;
  logic [7:0]          next_index = '0;
  logic [LIMIT_W-1:0]  wait_polls = '0;
  logic [LIMIT_W-1:0]  poll_limit = LIMIT_RESET;
  logic                ack_level  = 1'b0;

  i2c_master_transaction_sequencer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- packing

  function automatic logic [i2cseq_pkg::IN_TDATA_W-1:0] to_bus(i2cseq_pkg::item_t it);
    return {2'b00, it.rx_not_empty, it.transfer_finished, it.tx_empty,
            it.ack_failure, it.address_acked, it.start_sent, it.bus_busy,
            it.rx_byte, it.tx_byte, it.length, it.target_address};
  endfunction

  function automatic i2cseq_pkg::item_t from_bus(logic [i2cseq_pkg::IN_TDATA_W-1:0] d,
                                                 logic [i2cseq_pkg::IN_TUSER_W-1:0] u);
    i2cseq_pkg::item_t it;
    it.command           = u;
    it.target_address    = d[6:0];
    it.length            = d[14:7];
    it.tx_byte           = d[22:15];
    it.rx_byte           = d[30:23];
    it.bus_busy          = d[31];
    it.start_sent        = d[32];
    it.address_acked     = d[33];
    it.ack_failure       = d[34];
    it.tx_empty          = d[35];
    it.transfer_finished = d[36];
    it.rx_not_empty      = d[37];
    return it;
  endfunction

  function automatic i2cseq_pkg::result_t from_result_bus(
      logic [i2cseq_pkg::OUT_TDATA_W-1:0] d);
    i2cseq_pkg::result_t r;
    r.issue_start = d[0];
    r.write_data  = d[1];
    r.data_out    = d[9:2];
    r.issue_stop  = d[10];
    r.clear_fault = d[11];
    r.ack_enable  = d[12];
    r.read_valid  = d[13];
    r.read_data   = d[21:14];
    r.byte_index  = d[29:22];
    r.done_res    = d[30];
    r.failed      = d[31];
    return r;
  endfunction

  // -------------------------------------------------------------- predictor

  // one more poll without the awaited flag; the counter saturates
  function automatic bit poll_timed_out();
    if (wait_polls != LIMIT_MAX) wait_polls = wait_polls + 1'b1;
    return wait_polls >= poll_limit;
  endfunction

  function automatic i2cseq_pkg::result_t step_sequencer(i2cseq_pkg::item_t it);
    i2cseq_pkg::result_t r;
    r = '0;
    if (it.command == i2cseq_pkg::CMD_START_WRITE ||
        it.command == i2cseq_pkg::CMD_START_READ) begin
      // starts outside idle are dropped
      if (seq_phase == SEQ_IDLE) begin
        read_xfer  = (it.command == i2cseq_pkg::CMD_START_READ);
        target     = it.target_address;
        xfer_len   = it.length;
        next_index = '0;
        wait_polls = '0;
        seq_phase  = SEQ_BUS_FREE;
      end
    end else begin
      case (seq_phase)
        SEQ_BUS_FREE: begin
          if (!it.bus_busy) begin
            r.issue_start = 1'b1;
            wait_polls    = '0;
            seq_phase     = SEQ_START_SENT;
          end else if (poll_timed_out()) begin
            r.done_res = 1'b1;
            r.failed   = 1'b1;
            seq_phase  = SEQ_IDLE;
          end
        end
        SEQ_START_SENT: begin
          if (it.start_sent) begin
            r.write_data = 1'b1;
            r.data_out   = {target, read_xfer};
            wait_polls   = '0;
            seq_phase    = SEQ_ADDR_ACK;
          end else if (poll_timed_out()) begin
            r.done_res = 1'b1;
            r.failed   = 1'b1;
            seq_phase  = SEQ_IDLE;
          end
        end
        SEQ_ADDR_ACK: begin
          if (it.ack_failure) begin
            r.clear_fault = 1'b1;
            r.issue_stop  = 1'b1;
            r.done_res    = 1'b1;
            r.failed      = 1'b1;
            seq_phase     = SEQ_IDLE;
          end else if (it.address_acked) begin
            wait_polls = '0;
            if (read_xfer) ack_level = (xfer_len != 8'd1);
            if (xfer_len == 8'd0) begin
              r.issue_stop = 1'b1;
              r.done_res   = 1'b1;
              seq_phase    = SEQ_IDLE;
            end else begin
              seq_phase = SEQ_DATA;
            end
          end else if (poll_timed_out()) begin
            r.issue_stop = 1'b1;
            r.done_res   = 1'b1;
            r.failed     = 1'b1;
            seq_phase    = SEQ_IDLE;
          end
        end
        SEQ_DATA: begin
          if (read_xfer) begin
            if (it.rx_not_empty) begin
              r.read_valid = 1'b1;
              r.read_data  = it.rx_byte;
              r.byte_index = next_index;
              next_index   = next_index + 8'd1;
              wait_polls   = '0;
              if (next_index >= xfer_len) begin
                r.issue_stop = 1'b1;
                r.done_res   = 1'b1;
                seq_phase    = SEQ_IDLE;
              end else if ({1'b0, next_index} + 9'd1 == {1'b0, xfer_len}) begin
                // nack the last byte
                ack_level = 1'b0;
              end
            end else if (poll_timed_out()) begin
              r.issue_stop = 1'b1;
              r.done_res   = 1'b1;
              r.failed     = 1'b1;
              seq_phase    = SEQ_IDLE;
            end
          end else begin
            if (it.ack_failure) begin
              r.clear_fault = 1'b1;
              r.issue_stop  = 1'b1;
              r.done_res    = 1'b1;
              r.failed      = 1'b1;
              seq_phase     = SEQ_IDLE;
            end else if (it.tx_empty) begin
              r.write_data = 1'b1;
              r.data_out   = it.tx_byte;
              r.byte_index = next_index;
              next_index   = next_index + 8'd1;
              if (next_index >= xfer_len) seq_phase = SEQ_BYTE_DONE;
            end
          end
        end
        SEQ_BYTE_DONE: begin
          if (it.ack_failure) begin
            r.clear_fault = 1'b1;
            r.issue_stop  = 1'b1;
            r.done_res    = 1'b1;
            r.failed      = 1'b1;
            seq_phase     = SEQ_IDLE;
          end else if (it.transfer_finished) begin
            r.issue_stop = 1'b1;
            r.done_res   = 1'b1;
            seq_phase    = SEQ_IDLE;
          end
        end
        default: seq_phase = SEQ_IDLE;
      endcase
    end
    r.ack_enable = ack_level;
    return r;
  endfunction

  // -------------------------------------------------------------- stimulus

  function automatic i2cseq_pkg::item_t random_item();
    i2cseq_pkg::item_t it;
    it.command           = 2'($urandom_range(3));
    it.target_address    = 7'($urandom_range(127));
    it.length            = 8'($urandom_range(255));
    it.tx_byte           = 8'($urandom_range(255));
    it.rx_byte           = 8'($urandom_range(255));
    it.bus_busy          = 1'($urandom_range(1));
    it.start_sent        = 1'($urandom_range(1));
    it.address_acked     = 1'($urandom_range(1));
    it.ack_failure       = 1'($urandom_range(1));
    it.tx_empty          = 1'($urandom_range(1));
    it.transfer_finished = 1'($urandom_range(1));
    it.rx_not_empty      = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic i2cseq_pkg::item_t start_of(logic [1:0] cmd, logic [6:0] addr,
                                                 logic [7:0] len);
    i2cseq_pkg::item_t it;
    it                = random_item();
    it.command        = cmd;
    it.target_address = addr;
    it.length         = len;
    return it;
  endfunction

  function automatic i2cseq_pkg::item_t poll_of(logic [6:0] flags, logic [7:0] tx,
                                                logic [7:0] rx);
    i2cseq_pkg::item_t it;
    it         = random_item();
    it.command = i2cseq_pkg::CMD_POLL;
    it.tx_byte = tx;
    it.rx_byte = rx;
    {it.rx_not_empty, it.transfer_finished, it.tx_empty, it.ack_failure,
     it.address_acked, it.start_sent, it.bus_busy} = flags;
    return it;
  endfunction

  // poll aimed at one phase: hit carries the awaited flag, a miss does not
  function automatic i2cseq_pkg::item_t make_poll(seq_phase_e ph, bit hit, bit rd);
    i2cseq_pkg::item_t it;
    it         = random_item();
    it.command = ($urandom_range(9) == 0) ? CMD_SPARE : i2cseq_pkg::CMD_POLL;
    case (ph)
      SEQ_BUS_FREE:   it.bus_busy = !hit;
      SEQ_START_SENT: it.start_sent = hit;
      SEQ_ADDR_ACK: begin
        it.address_acked = hit;
        it.ack_failure   = 1'b0;
      end
      SEQ_DATA: begin
        if (rd) begin
          it.rx_not_empty = hit;
        end else begin
          it.tx_empty    = hit;
          it.ack_failure = 1'b0;
        end
      end
      SEQ_BYTE_DONE: begin
        it.transfer_finished = hit;
        it.ack_failure       = 1'b0;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic push_item(input i2cseq_pkg::item_t it);
    plan_t p;
    p.kind        = PLAN_ITEM;
    p.it          = it;
    p.write_limit = 1'b0;
    p.limit       = '0;
    p.send_pct    = 0;
    p.stall_pct   = 0;
    poll_plan.push_back(p);
    planned_items++;
  endtask

  task automatic push_phase(input bit write_limit, input int limit,
                            input int send_pct, input int stall_pct);
    plan_t p;
    p.kind        = PLAN_PHASE;
    p.it          = '0;
    p.write_limit = write_limit;
    p.limit       = LIMIT_W'(limit);
    p.send_pct    = send_pct;
    p.stall_pct   = stall_pct;
    poll_plan.push_back(p);
  endtask

  task automatic push_pause();
    plan_t p;
    p.kind        = PLAN_PAUSE;
    p.it          = '0;
    p.write_limit = 1'b0;
    p.limit       = '0;
    p.send_pct    = 0;
    p.stall_pct   = 0;
    poll_plan.push_back(p);
  endtask

  // misses then the awaited flag; sometimes the wait is run out to its timeout
  task automatic add_bounded(input seq_phase_e ph, input int tmo, input bit rd,
                             output bit ended);
    int misses;
    if (tmo <= 40 && $urandom_range(99) < 12) misses = tmo;
    else misses = $urandom_range(3);
    ended = (misses >= tmo);
    if (ended) misses = tmo;
    repeat (misses) push_item(make_poll(ph, 1'b0, rd));
    if (!ended) push_item(make_poll(ph, 1'b1, rd));
  endtask

  task automatic add_transaction(input int limit, input int len);
    i2cseq_pkg::item_t it;
    bit                rd;
    bit                ended;
    int                tmo;
    tmo = (limit == 0) ? 1 : limit;
    rd  = 1'($urandom_range(1));
    push_item(start_of(rd ? i2cseq_pkg::CMD_START_READ : i2cseq_pkg::CMD_START_WRITE,
                       7'($urandom_range(127)), 8'(len)));
    if ($urandom_range(99) < 5) begin
      it         = random_item();
      it.command = $urandom_range(1) ? i2cseq_pkg::CMD_START_READ
                                     : i2cseq_pkg::CMD_START_WRITE;
      push_item(it);
    end
    add_bounded(SEQ_BUS_FREE, tmo, rd, ended);
    if (ended) return;
    add_bounded(SEQ_START_SENT, tmo, rd, ended);
    if (ended) return;
    if ($urandom_range(99) < 5) begin
      it             = make_poll(SEQ_ADDR_ACK, 1'($urandom_range(1)), rd);
      it.ack_failure = 1'b1;
      push_item(it);
      return;
    end
    add_bounded(SEQ_ADDR_ACK, tmo, rd, ended);
    if (ended) return;
    for (int i = 0; i < len; i++) begin
      if (rd) begin
        add_bounded(SEQ_DATA, tmo, rd, ended);
        if (ended) return;
      end else begin
        repeat ($urandom_range(2)) push_item(make_poll(SEQ_DATA, 1'b0, rd));
        it = make_poll(SEQ_DATA, 1'b1, rd);
        if ($urandom_range(99) < 3) begin
          it.ack_failure = 1'b1;
          push_item(it);
          return;
        end
        push_item(it);
      end
    end
    if (!rd && len != 0) begin
      repeat ($urandom_range(2)) push_item(make_poll(SEQ_BYTE_DONE, 1'b0, rd));
      it = make_poll(SEQ_BYTE_DONE, 1'b1, rd);
      if ($urandom_range(99) < 8) it.ack_failure = 1'b1;
      push_item(it);
    end
  endtask

  task automatic add_random(input int limit, input int count);
    int stop_at;
    int r;
    stop_at = planned_items + count;
    while (planned_items < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_item(random_item());
      end else if (r < 18) begin
        add_transaction(limit, 0);
      end else if (r < 85) begin
        add_transaction(limit, $urandom_range(1, 6));
      end else if (r < 97) begin
        add_transaction(limit, $urandom_range(7, 40));
      end else begin
        add_transaction(limit, $urandom_range(41, 100));
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive
    plan_t head;
    logic  next_valid;
    logic  next_cfg;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid     <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(step_sequencer(from_bus(s_axis_tdata, s_axis_tuser)));
      if (cfg_valid && cfg_ready)
        poll_limit = cfg_data;

      if (expected_results.size() == 0 && !s_axis_tvalid && !m_axis_tvalid)
        quiet_cycles++;
      else
        quiet_cycles = 0;

      next_valid = 1'b0;
      next_cfg   = 1'b0;
      if (s_axis_tvalid && !s_axis_tready) begin
        next_valid = 1'b1;
      end else if (cfg_valid && !cfg_ready) begin
        next_cfg = 1'b1;
      end else if (poll_plan.size() != 0) begin
        head = poll_plan[0];
        if (head.kind == PLAN_ITEM) begin
          if ($urandom_range(99) >= send_idle_pct) begin
            head = poll_plan.pop_front();
            next_valid = 1'b1;
            s_axis_tdata <= to_bus(head.it);
            s_axis_tuser <= head.it.command;
          end
        end else if (quiet_cycles >= SETTLE_CYCLES) begin
          // block drained: safe to change the limit or resume
          head = poll_plan.pop_front();
          if (head.kind == PLAN_PHASE) begin
            send_idle_pct = head.send_pct;
            stall_pct <= head.stall_pct;
            if (head.write_limit) begin
              next_cfg = 1'b1;
              cfg_data <= head.limit;
            end
          end
        end
      end
      s_axis_tvalid <= next_valid;
      cfg_valid     <= next_cfg;
    end
  end

  // --------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : observe
    i2cseq_pkg::result_t seen;
    i2cseq_pkg::result_t want;
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = from_result_bus(m_axis_tdata);
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        check_flag("issue_start", want.issue_start, seen.issue_start);
        check_flag("write_data", want.write_data, seen.write_data);
        check_field("data_out", want.data_out, seen.data_out);
        check_flag("issue_stop", want.issue_stop, seen.issue_stop);
        check_flag("clear_fault", want.clear_fault, seen.clear_fault);
        check_flag("ack_enable", want.ack_enable, seen.ack_enable);
        check_flag("read_valid", want.read_valid, seen.read_valid);
        check_field("read_data", want.read_data, seen.read_data);
        check_field("byte_index", want.byte_index, seen.byte_index);
        check_flag("done_res", want.done_res, seen.done_res);
        check_flag("failed", want.failed, seen.failed);
      end
    end
  end

  // -------------------------------------------------------------- sequence

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : run
    int lim;

    // directed part, limit of one poll
    push_phase(1'b1, 1, 0, 0);
    push_item(poll_of(7'h7F, 8'hFF, 8'hFF));                 // poll while idle
    push_item(start_of(i2cseq_pkg::CMD_START_WRITE, 7'h7F, 8'd1));
    push_item(start_of(i2cseq_pkg::CMD_START_READ, 7'h00, 8'd0));   // dropped, active
    push_item(poll_of(7'h00, 8'h00, 8'h00));
    push_item(poll_of(F_SB, 8'h00, 8'h00));
    push_item(poll_of(F_ADDR, 8'h00, 8'h00));
    push_item(poll_of(F_TXE, 8'hFF, 8'h00));
    push_item(poll_of(F_BTF, 8'h00, 8'h00));
    push_item(start_of(i2cseq_pkg::CMD_START_READ, 7'h00, 8'd2));
    push_item(poll_of(7'h00, 8'h00, 8'h00));
    push_item(poll_of(F_SB, 8'h00, 8'h00));
    push_item(poll_of(F_ADDR, 8'h00, 8'h00));
    push_item(poll_of(F_RXNE, 8'h00, 8'hFF));
    push_item(poll_of(F_RXNE, 8'hFF, 8'h00));
    push_item(start_of(i2cseq_pkg::CMD_START_WRITE, 7'h2A, 8'd0));
    begin : spare_poll
      i2cseq_pkg::item_t it;
      it         = poll_of(F_BUSY, 8'h00, 8'h00);
      it.command = CMD_SPARE;                                // busy timeout via spare code
      push_item(it);
    end
    push_item(start_of(i2cseq_pkg::CMD_START_READ, 7'h7F, 8'd0));   // zero length read
    push_item(poll_of(7'h00, 8'h00, 8'h00));
    push_item(poll_of(F_SB, 8'h00, 8'h00));
    push_item(poll_of(F_ADDR, 8'h00, 8'h00));
    push_item(start_of(i2cseq_pkg::CMD_START_WRITE, 7'h01, 8'hFF));
    push_item(poll_of(7'h00, 8'h00, 8'h00));
    push_item(poll_of(F_SB, 8'h00, 8'h00));
    push_item(poll_of(F_AF | F_ADDR, 8'h00, 8'h00));        // fault wins over ack
    add_random(1, 30);

    push_phase(1'b1, int'(LIMIT_MAX), 82, 0);
    add_transaction(int'(LIMIT_MAX), 255);
    add_random(int'(LIMIT_MAX), 15);
    push_pause();
    add_random(int'(LIMIT_MAX), 15);

    push_phase(1'b1, 0, 0, 82);
    add_random(0, 40);

    lim = $urandom_range(2, 6);
    push_phase(1'b1, lim, 38, 38);
    add_random(lim, 50);

    lim = $urandom_range(7, 20);
    push_phase(1'b1, lim, 0, 0);
    add_random(lim, 30);

    lim = $urandom_range(1, int'(LIMIT_MAX));
    push_phase(1'b1, lim, 38, 38);
    add_random(lim, 30);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (poll_plan.size() != 0 || s_axis_tvalid || cfg_valid ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> i2c_master_transaction_sequencer.f
rtl/i2cseq_pkg.sv
rtl/i2cseq_in_stage.sv
rtl/i2cseq_fsm.sv
rtl/i2cseq_out_stage.sv
rtl/i2c_master_transaction_sequencer.sv
verif/tb_top.sv
